// ===== rtl/ihtk_pkg.sv =====
// Shared widths, codes, command set and status type of the indexed max-heap block.
package ihtk_pkg;

  localparam int ID_W     = 6;
  localparam int KEY_W    = 31;
  localparam int TAKE_W   = 7;
  localparam int TOTAL_W  = 37;
  localparam int ACT_W    = 2;
  localparam int STATUS_W = 2;
  localparam int NUM_IDS  = 2 ** ID_W;
  localparam int MAX_TAKE = 64;

  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_RAISE  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_TAKE   = 2'd2;
  localparam logic [ACT_W-1:0] ACT_REPORT = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NONE = 2'd2;

  typedef logic [4:0] cmd_t;

  localparam cmd_t CMD_IDLE      = 5'd0;
  localparam cmd_t CMD_LOAD      = 5'd1;
  localparam cmd_t CMD_INS_WR    = 5'd2;
  localparam cmd_t CMD_RAISE_WR  = 5'd3;
  localparam cmd_t CMD_LOAD_S    = 5'd4;
  localparam cmd_t CMD_UP_RD0    = 5'd5;
  localparam cmd_t CMD_UP_RD1    = 5'd6;
  localparam cmd_t CMD_UP_RD2    = 5'd7;
  localparam cmd_t CMD_UP_W1     = 5'd8;
  localparam cmd_t CMD_UP_W2     = 5'd9;
  localparam cmd_t CMD_TOP_RD0   = 5'd10;
  localparam cmd_t CMD_TOP_RD1   = 5'd11;
  localparam cmd_t CMD_TOP_TAKE  = 5'd12;
  localparam cmd_t CMD_DN_RD0    = 5'd13;
  localparam cmd_t CMD_DN_RD1    = 5'd14;
  localparam cmd_t CMD_DN_RD2    = 5'd15;
  localparam cmd_t CMD_DN_CMP    = 5'd16;
  localparam cmd_t CMD_DN_W1     = 5'd17;
  localparam cmd_t CMD_DN_W2     = 5'd18;
  localparam cmd_t CMD_NEXT      = 5'd19;
  localparam cmd_t CMD_RP_INIT   = 5'd20;
  localparam cmd_t CMD_RP_RD     = 5'd21;
  localparam cmd_t CMD_RP_WR     = 5'd22;
  localparam cmd_t CMD_EMIT_TAKE = 5'd23;
  localparam cmd_t CMD_EMIT_OK   = 5'd24;
  localparam cmd_t CMD_EMIT_FULL = 5'd25;
  localparam cmd_t CMD_EMIT_NONE = 5'd26;
  localparam cmd_t CMD_EMIT_SUM  = 5'd27;

  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             full;
    logic             none;
    logic             up_stop;
    logic             up_swap;
    logic             dn_stop;
    logic             dn_go;
    logic             take_last;
    logic             rp_done;
    logic             out_free;
  } stat_t;

endpackage

// ===== rtl/ihtk_if.sv =====
// Valid/ready channel interfaces for request and result transfers.
interface ihtk_in_if;
  import ihtk_pkg::*;
  logic                valid;
  logic                ready;
  logic [ACT_W-1:0]    action;
  logic [ID_W-1:0]     entry_id;
  logic [KEY_W-1:0]    key_value;
  logic [TAKE_W-1:0]   take_count;
  modport source(output valid, action, entry_id, key_value, take_count, input ready);
  modport sink(input valid, action, entry_id, key_value, take_count, output ready);
endinterface

interface ihtk_out_if;
  import ihtk_pkg::*;
  logic                valid;
  logic                ready;
  logic [ID_W-1:0]     out_id;
  logic [KEY_W-1:0]    out_key;
  logic [TOTAL_W-1:0]  total;
  logic [STATUS_W-1:0] status;
  logic                last;
  modport source(output valid, out_id, out_key, total, status, last, input ready);
  modport sink(input valid, out_id, out_key, total, status, last, output ready);
endinterface

// ===== rtl/ihtk_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ihtk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/ihtk_ctrl.sv =====
// Controller state machine sequencing insert, raise, take and report operations.
module ihtk_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output ihtk_pkg::cmd_t cmd,
  input  ihtk_pkg::stat_t stat
);
  import ihtk_pkg::*;

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_DISPATCH = 5'd1;
  localparam logic [4:0] S_INS_WR   = 5'd2;
  localparam logic [4:0] S_RAISE_WR = 5'd3;
  localparam logic [4:0] S_LOAD_S   = 5'd4;
  localparam logic [4:0] S_UP_RD0   = 5'd5;
  localparam logic [4:0] S_UP_RD1   = 5'd6;
  localparam logic [4:0] S_UP_RD2   = 5'd7;
  localparam logic [4:0] S_UP_CMP   = 5'd8;
  localparam logic [4:0] S_UP_W1    = 5'd9;
  localparam logic [4:0] S_UP_W2    = 5'd10;
  localparam logic [4:0] S_UP_DONE  = 5'd11;
  localparam logic [4:0] S_TOP_RD0  = 5'd12;
  localparam logic [4:0] S_TOP_RD1  = 5'd13;
  localparam logic [4:0] S_TOP_TAKE = 5'd14;
  localparam logic [4:0] S_TK_EMIT  = 5'd15;
  localparam logic [4:0] S_DN_RD0   = 5'd16;
  localparam logic [4:0] S_DN_RD1   = 5'd17;
  localparam logic [4:0] S_DN_RD2   = 5'd18;
  localparam logic [4:0] S_DN_CMP   = 5'd19;
  localparam logic [4:0] S_DN_W1    = 5'd20;
  localparam logic [4:0] S_DN_W2    = 5'd21;
  localparam logic [4:0] S_DN_DONE  = 5'd22;
  localparam logic [4:0] S_RP_INIT  = 5'd23;
  localparam logic [4:0] S_RP_RD    = 5'd24;
  localparam logic [4:0] S_RP_WR    = 5'd25;
  localparam logic [4:0] S_RES_OK   = 5'd26;
  localparam logic [4:0] S_RES_FULL = 5'd27;
  localparam logic [4:0] S_RES_NONE = 5'd28;
  localparam logic [4:0] S_RES_SUM  = 5'd29;

  logic [4:0] state;
  logic [4:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = CMD_IDLE;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd        = CMD_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.act)
          ACT_INSERT: state_next = stat.full ? S_RES_FULL : S_INS_WR;
          ACT_RAISE:  state_next = S_RAISE_WR;
          default:    state_next = stat.none ? S_RES_NONE : S_TOP_RD0;
        endcase
      end
      S_INS_WR: begin
        cmd        = CMD_INS_WR;
        state_next = S_UP_RD0;
      end
      S_RAISE_WR: begin
        cmd        = CMD_RAISE_WR;
        state_next = S_LOAD_S;
      end
      S_LOAD_S: begin
        cmd        = CMD_LOAD_S;
        state_next = S_UP_RD0;
      end
      S_UP_RD0: begin
        cmd        = CMD_UP_RD0;
        state_next = stat.up_stop ? S_UP_DONE : S_UP_RD1;
      end
      S_UP_RD1: begin
        cmd        = CMD_UP_RD1;
        state_next = S_UP_RD2;
      end
      S_UP_RD2: begin
        cmd        = CMD_UP_RD2;
        state_next = S_UP_CMP;
      end
      S_UP_CMP: begin
        state_next = stat.up_swap ? S_UP_W1 : S_UP_DONE;
      end
      S_UP_W1: begin
        cmd        = CMD_UP_W1;
        state_next = S_UP_W2;
      end
      S_UP_W2: begin
        cmd        = CMD_UP_W2;
        state_next = S_UP_RD0;
      end
      S_UP_DONE: begin
        if (stat.act == ACT_REPORT) begin
          state_next = stat.rp_done ? S_RES_SUM : S_RP_RD;
        end else begin
          state_next = S_RES_OK;
        end
      end
      S_TOP_RD0: begin
        cmd        = CMD_TOP_RD0;
        state_next = S_TOP_RD1;
      end
      S_TOP_RD1: begin
        cmd        = CMD_TOP_RD1;
        state_next = S_TOP_TAKE;
      end
      S_TOP_TAKE: begin
        cmd        = CMD_TOP_TAKE;
        state_next = (stat.act == ACT_TAKE) ? S_TK_EMIT : S_DN_RD0;
      end
      S_TK_EMIT: begin
        if (stat.out_free) begin
          cmd        = CMD_EMIT_TAKE;
          state_next = S_DN_RD0;
        end
      end
      S_DN_RD0: begin
        cmd        = CMD_DN_RD0;
        state_next = stat.dn_stop ? S_DN_DONE : S_DN_RD1;
      end
      S_DN_RD1: begin
        cmd        = CMD_DN_RD1;
        state_next = S_DN_RD2;
      end
      S_DN_RD2: begin
        cmd        = CMD_DN_RD2;
        state_next = S_DN_CMP;
      end
      S_DN_CMP: begin
        cmd        = CMD_DN_CMP;
        state_next = stat.dn_go ? S_DN_W1 : S_DN_DONE;
      end
      S_DN_W1: begin
        cmd        = CMD_DN_W1;
        state_next = S_DN_W2;
      end
      S_DN_W2: begin
        cmd        = CMD_DN_W2;
        state_next = S_DN_RD0;
      end
      S_DN_DONE: begin
        cmd = CMD_NEXT;
        if (stat.take_last) begin
          state_next = (stat.act == ACT_TAKE) ? S_IDLE : S_RP_INIT;
        end else begin
          state_next = S_TOP_RD0;
        end
      end
      S_RP_INIT: begin
        cmd        = CMD_RP_INIT;
        state_next = S_RP_RD;
      end
      S_RP_RD: begin
        cmd        = CMD_RP_RD;
        state_next = S_RP_WR;
      end
      S_RP_WR: begin
        cmd        = CMD_RP_WR;
        state_next = S_LOAD_S;
      end
      S_RES_OK: begin
        if (stat.out_free) begin
          cmd        = CMD_EMIT_OK;
          state_next = S_IDLE;
        end
      end
      S_RES_FULL: begin
        if (stat.out_free) begin
          cmd        = CMD_EMIT_FULL;
          state_next = S_IDLE;
        end
      end
      S_RES_NONE: begin
        if (stat.out_free) begin
          cmd        = CMD_EMIT_NONE;
          state_next = S_IDLE;
        end
      end
      S_RES_SUM: begin
        if (stat.out_free) begin
          cmd        = CMD_EMIT_SUM;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/ihtk_dp.sv =====
// Datapath: heap, key, slot-map and taken-list memories, working registers, result register.
module ihtk_dp #(
  parameter int CAPACITY = 64,
  parameter int KEY_BITS = 31
) (
  input  logic                           clk,
  input  logic                           rst,
  input  ihtk_pkg::cmd_t                 cmd,
  output ihtk_pkg::stat_t                stat,
  input  logic [ihtk_pkg::ACT_W-1:0]     action,
  input  logic [ihtk_pkg::ID_W-1:0]      entry_id,
  input  logic [ihtk_pkg::KEY_W-1:0]     key_value,
  input  logic [ihtk_pkg::TAKE_W-1:0]    take_count,
  ihtk_out_if.source                     out_ch
);
  import ihtk_pkg::*;

  localparam int SW = $clog2(CAPACITY);
  localparam int FW = $clog2(CAPACITY + 1);
  localparam int LW = SW + 2;
  localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int NW = TAKE_W;
  localparam int TW = $clog2(MAX_TAKE);
  localparam int CW = (FW > NW) ? FW : NW;

  // control
  logic [FW-1:0] fill;
  logic [NW-1:0] n;
  logic [NW-1:0] ntot;
  logic          ovalid;

  // working registers
  logic [ACT_W-1:0]   act;
  logic [ID_W-1:0]    in_id;
  logic [KW-1:0]      in_key;
  logic [SW-1:0]      s;
  logic [SW-1:0]      c;
  logic [ID_W-1:0]    id_s;
  logic [ID_W-1:0]    id_c;
  logic [ID_W-1:0]    id_l;
  logic [ID_W-1:0]    id_r;
  logic [KW-1:0]      key_s;
  logic [KW-1:0]      key_l;
  logic [KW-1:0]      key_t;
  logic [TOTAL_W-1:0] sum;

  logic [ID_W-1:0]     o_id;
  logic [KEY_W-1:0]    o_key;
  logic [TOTAL_W-1:0]  o_total;
  logic [STATUS_W-1:0] o_status;
  logic                o_last;

  // memory ports
  logic            h_we;
  logic [SW-1:0]   h_waddr;
  logic [ID_W-1:0] h_wdata;
  logic [SW-1:0]   h_raddr;
  logic [ID_W-1:0] h_rdata;
  logic            k_we;
  logic [ID_W-1:0] k_waddr;
  logic [KW-1:0]   k_wdata;
  logic [ID_W-1:0] k_raddr;
  logic [KW-1:0]   k_rdata;
  logic            m_we;
  logic [ID_W-1:0] m_waddr;
  logic [SW-1:0]   m_wdata;
  logic [ID_W-1:0] m_raddr;
  logic [SW-1:0]   m_rdata;
  logic            t_we;
  logic [TW-1:0]   t_waddr;
  logic [ID_W-1:0] t_id_wdata;
  logic [KW-1:0]   t_key_wdata;
  logic [TW-1:0]   t_raddr;
  logic [ID_W-1:0] t_id_rdata;
  logic [KW-1:0]   t_key_rdata;

  // derived
  logic [SW-1:0] sm1;
  logic [SW-1:0] p;
  logic [LW-1:0] l;
  logic [LW-1:0] r;
  logic [LW-1:0] fill_x;
  logic          has_r;
  logic          pick_l;
  logic          out_free;
  logic          emit;
  logic [CW-1:0] lim_f;
  logic [NW-1:0] ntot_calc;

  assign sm1    = s - SW'(1);
  assign p      = sm1 >> 1;
  assign l      = {1'b0, s, 1'b1};
  assign r      = l + LW'(1);
  assign fill_x = LW'(fill);
  assign has_r  = r < fill_x;
  assign pick_l = !has_r || (key_l > k_rdata);

  assign out_free = !ovalid || out_ch.ready;
  assign emit = (cmd == CMD_EMIT_TAKE) || (cmd == CMD_EMIT_OK) || (cmd == CMD_EMIT_FULL) ||
                (cmd == CMD_EMIT_NONE) || (cmd == CMD_EMIT_SUM);

  assign lim_f     = (CW'(fill) < CW'(MAX_TAKE)) ? CW'(fill) : CW'(MAX_TAKE);
  assign ntot_calc = (CW'(take_count) < lim_f) ? take_count : NW'(lim_f);

  assign stat.act       = act;
  assign stat.full      = (fill == FW'(CAPACITY));
  assign stat.none      = (ntot == '0);
  assign stat.up_stop   = (s == '0) || (LW'(s) >= fill_x);
  assign stat.up_swap   = k_rdata < key_s;
  assign stat.dn_stop   = l >= fill_x;
  assign stat.dn_go     = has_r ? ((key_s < key_l) || (key_s < k_rdata)) : (key_l > key_s);
  assign stat.take_last = ((n + NW'(1)) == ntot);
  assign stat.rp_done   = (n == ntot);
  assign stat.out_free  = out_free;

  always_comb begin
    h_we        = 1'b0;
    h_waddr     = '0;
    h_wdata     = '0;
    h_raddr     = '0;
    k_we        = 1'b0;
    k_waddr     = '0;
    k_wdata     = '0;
    k_raddr     = '0;
    m_we        = 1'b0;
    m_waddr     = '0;
    m_wdata     = '0;
    m_raddr     = '0;
    t_we        = 1'b0;
    t_waddr     = '0;
    t_id_wdata  = '0;
    t_key_wdata = '0;
    t_raddr     = '0;
    case (cmd)
      CMD_INS_WR: begin
        h_we    = 1'b1;
        h_waddr = fill[SW-1:0];
        h_wdata = in_id;
        m_we    = 1'b1;
        m_waddr = in_id;
        m_wdata = fill[SW-1:0];
        k_we    = 1'b1;
        k_waddr = in_id;
        k_wdata = in_key;
      end
      CMD_RAISE_WR: begin
        k_we    = 1'b1;
        k_waddr = in_id;
        k_wdata = in_key;
        m_raddr = in_id;
      end
      CMD_UP_RD0: begin
        h_raddr = s;
      end
      CMD_UP_RD1: begin
        k_raddr = h_rdata;
        h_raddr = p;
      end
      CMD_UP_RD2: begin
        k_raddr = h_rdata;
      end
      CMD_UP_W1: begin
        h_we    = 1'b1;
        h_waddr = p;
        h_wdata = id_s;
        m_we    = 1'b1;
        m_waddr = id_s;
        m_wdata = p;
      end
      CMD_UP_W2: begin
        h_we    = 1'b1;
        h_waddr = s;
        h_wdata = id_c;
        m_we    = 1'b1;
        m_waddr = id_c;
        m_wdata = s;
      end
      CMD_TOP_RD0: begin
        h_raddr = '0;
      end
      CMD_TOP_RD1: begin
        k_raddr = h_rdata;
      end
      CMD_TOP_TAKE: begin
        k_we        = 1'b1;
        k_waddr     = id_s;
        k_wdata     = '0;
        t_we        = 1'b1;
        t_waddr     = n[TW-1:0];
        t_id_wdata  = id_s;
        t_key_wdata = k_rdata;
      end
      CMD_DN_RD0: begin
        h_raddr = l[SW-1:0];
      end
      CMD_DN_RD1: begin
        k_raddr = h_rdata;
        h_raddr = r[SW-1:0];
      end
      CMD_DN_RD2: begin
        k_raddr = h_rdata;
      end
      CMD_DN_W1: begin
        h_we    = 1'b1;
        h_waddr = s;
        h_wdata = id_c;
        m_we    = 1'b1;
        m_waddr = id_c;
        m_wdata = s;
      end
      CMD_DN_W2: begin
        h_we    = 1'b1;
        h_waddr = c;
        h_wdata = id_s;
        m_we    = 1'b1;
        m_waddr = id_s;
        m_wdata = c;
      end
      CMD_RP_RD: begin
        t_raddr = n[TW-1:0];
      end
      CMD_RP_WR: begin
        k_we    = 1'b1;
        k_waddr = t_id_rdata;
        k_wdata = t_key_rdata;
        m_raddr = t_id_rdata;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= '0;
      n      <= '0;
      ntot   <= '0;
      ovalid <= 1'b0;
    end else begin
      case (cmd)
        CMD_LOAD: begin
          n    <= '0;
          ntot <= ntot_calc;
        end
        CMD_INS_WR:  fill <= fill + FW'(1);
        CMD_NEXT:    n <= n + NW'(1);
        CMD_RP_INIT: n <= '0;
        CMD_RP_WR:   n <= n + NW'(1);
        default: begin
        end
      endcase
      if (emit) begin
        ovalid <= 1'b1;
      end else if (out_ch.ready) begin
        ovalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD: begin
        act    <= action;
        in_id  <= entry_id;
        in_key <= key_value[KW-1:0];
        sum    <= '0;
      end
      CMD_INS_WR: s <= fill[SW-1:0];
      CMD_LOAD_S: s <= m_rdata;
      CMD_UP_RD1: id_s <= h_rdata;
      CMD_UP_RD2: begin
        key_s <= k_rdata;
        id_c  <= h_rdata;
      end
      CMD_UP_W2: s <= p;
      CMD_TOP_RD1: id_s <= h_rdata;
      CMD_TOP_TAKE: begin
        key_t <= k_rdata;
        s     <= '0;
        key_s <= '0;
      end
      CMD_DN_RD1: id_l <= h_rdata;
      CMD_DN_RD2: begin
        key_l <= k_rdata;
        id_r  <= h_rdata;
      end
      CMD_DN_CMP: begin
        c    <= pick_l ? l[SW-1:0] : r[SW-1:0];
        id_c <= pick_l ? id_l : id_r;
      end
      CMD_DN_W2: s <= c;
      CMD_RP_INIT: sum <= '0;
      CMD_RP_WR: sum <= sum + TOTAL_W'(t_key_rdata);
      CMD_EMIT_TAKE: begin
        o_id     <= id_s;
        o_key    <= KEY_W'(key_t);
        o_total  <= '0;
        o_status <= ST_OK;
        o_last   <= stat.take_last;
      end
      CMD_EMIT_OK, CMD_EMIT_FULL, CMD_EMIT_NONE, CMD_EMIT_SUM: begin
        o_id     <= '0;
        o_key    <= '0;
        o_total  <= (cmd == CMD_EMIT_SUM) ? sum : '0;
        o_status <= (cmd == CMD_EMIT_FULL) ? ST_FULL :
                    (cmd == CMD_EMIT_NONE) ? ST_NONE : ST_OK;
        o_last   <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign out_ch.valid   = ovalid;
  assign out_ch.out_id  = o_id;
  assign out_ch.out_key = o_key;
  assign out_ch.total   = o_total;
  assign out_ch.status  = o_status;
  assign out_ch.last    = o_last;

  ihtk_ram #(.WIDTH(ID_W), .DEPTH(CAPACITY)) u_heap (
    .clk, .we(h_we), .waddr(h_waddr), .wdata(h_wdata), .raddr(h_raddr), .rdata(h_rdata)
  );

  ihtk_ram #(.WIDTH(KW), .DEPTH(NUM_IDS)) u_keys (
    .clk, .we(k_we), .waddr(k_waddr), .wdata(k_wdata), .raddr(k_raddr), .rdata(k_rdata)
  );

  ihtk_ram #(.WIDTH(SW), .DEPTH(NUM_IDS)) u_slot_map (
    .clk, .we(m_we), .waddr(m_waddr), .wdata(m_wdata), .raddr(m_raddr), .rdata(m_rdata)
  );

  ihtk_ram #(.WIDTH(ID_W), .DEPTH(MAX_TAKE)) u_taken_ids (
    .clk, .we(t_we), .waddr(t_waddr), .wdata(t_id_wdata), .raddr(t_raddr),
    .rdata(t_id_rdata)
  );

  ihtk_ram #(.WIDTH(KW), .DEPTH(MAX_TAKE)) u_taken_keys (
    .clk, .we(t_we), .waddr(t_waddr), .wdata(t_key_wdata), .raddr(t_raddr),
    .rdata(t_key_rdata)
  );

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(CAPACITY))
    else $error("fill count above capacity");

  a_take_bound: assert property (@(posedge clk) disable iff (rst)
    n <= ntot)
    else $error("take counter past its limit");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    emit |-> out_free)
    else $error("result register overwritten before transfer");

  a_up_root: assert property (@(posedge clk) disable iff (rst)
    (cmd == CMD_UP_W1) |-> (s != '0))
    else $error("sift-up swap at the root");

endmodule

// ===== rtl/indexed_max_heap_top_k.sv =====
// Indexed max-heap with top-k take and report, one request at a time.
// Insert: dispatch, write the entry, sift up (read, compare, swap per level climbed), emit;
// raise adds a slot load. Take, per entry: read and zero the root, emit, sift down, advance.
// Report skips the emit, then restores each entry (taken-list read, key write, sift-up).
// Results leave through an output register, so a request may enter while one waits; a take
// stalls while its previous result waits. Reset clears fill count and controller, not RAMs.
module indexed_max_heap_top_k #(
  parameter int CAPACITY = 64,
  parameter int KEY_BITS = 31
) (
  input logic        clk,
  input logic        rst,
  ihtk_in_if.sink    in_ch,
  ihtk_out_if.source out_ch
);
  import ihtk_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  in_ready;

  assign in_ch.ready = in_ready;

  ihtk_ctrl u_ctrl (
    .clk,
    .rst,
    .in_valid (in_ch.valid),
    .in_ready,
    .cmd,
    .stat
  );

  ihtk_dp #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS)) u_dp (
    .clk,
    .rst,
    .cmd,
    .stat,
    .action     (in_ch.action),
    .entry_id   (in_ch.entry_id),
    .key_value  (in_ch.key_value),
    .take_count (in_ch.take_count),
    .out_ch     (out_ch)
  );

endmodule

// ===== sim/ihtk_scoreboard.sv =====
// Checker: predicts heap results from observed requests and compares output transfers.
module ihtk_scoreboard (
  input  logic clk,
  input  logic rst,
  ihtk_in_if   in_ch,
  ihtk_out_if  out_ch,
  output int   errors,
  output int   pending,
  output int   results_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import ihtk_pkg::*;

  localparam int CAP = 64;

  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [KEY_W-1:0]    key;
    logic [TOTAL_W-1:0]  total;
    logic [STATUS_W-1:0] status;
    logic                last;
  } heap_result_t;

  logic [ID_W-1:0]  slots [CAP];
  logic [KEY_W-1:0] keys [NUM_IDS];
  int               slot_of [NUM_IDS];
  int               fill;
  heap_result_t     expected_q[$];

  function automatic void enqueue(heap_result_t r);
    expected_q.insert(expected_q.size(), r);
  endfunction

  function automatic logic [KEY_W-1:0] key_at(int s);
    return keys[slots[s]];
  endfunction

  function automatic void swap_slots(int a, int b);
    logic [ID_W-1:0] ia, ib;
    ia = slots[a];
    ib = slots[b];
    slots[a] = ib;
    slots[b] = ia;
    slot_of[ib] = a;
    slot_of[ia] = b;
  endfunction

  function automatic void sift_up(int s);
    int p;
    while (s > 0 && s < fill) begin
      p = (s - 1) / 2;
      if (!(key_at(p) < key_at(s))) break;
      swap_slots(p, s);
      s = p;
    end
  endfunction

  function automatic void sift_down(int s);
    int l, r, c;
    forever begin
      l = 2 * s + 1;
      r = 2 * s + 2;
      if (l >= fill) return;
      if (r < fill) begin
        if (!(key_at(s) < key_at(l) || key_at(s) < key_at(r))) return;
        c = (key_at(l) > key_at(r)) ? l : r;
      end else begin
        if (!(key_at(l) > key_at(s))) return;
        c = l;
      end
      swap_slots(s, c);
      s = c;
    end
  endfunction

  function automatic void predict(logic [ACT_W-1:0] act, logic [ID_W-1:0] id,
                                  logic [KEY_W-1:0] key, logic [TAKE_W-1:0] k);
    heap_result_t    r;
    logic [ID_W-1:0]  tid [MAX_TAKE];
    logic [KEY_W-1:0] tkey [MAX_TAKE];
    logic [TOTAL_W-1:0] sum;
    int n;
    r = '0;
    r.last = 1'b1;
    n = 0;
    sum = '0;
    case (act)
      ACT_INSERT: begin
        if (fill >= CAP) r.status = ST_FULL;
        else begin
          slots[fill] = id;
          slot_of[id] = fill;
          keys[id] = key;
          fill++;
          sift_up(fill - 1);
        end
        enqueue(r);
      end
      ACT_RAISE: begin
        keys[id] = key;
        sift_up(slot_of[id]);
        enqueue(r);
      end
      default: begin
        while (n < int'(k) && n < fill && n < MAX_TAKE) begin
          tid[n] = slots[0];
          tkey[n] = keys[slots[0]];
          keys[slots[0]] = '0;
          sift_down(0);
          n++;
        end
        if (n == 0) begin
          r.status = ST_NONE;
          enqueue(r);
        end else if (act == ACT_TAKE) begin
          for (int i = 0; i < n; i++) begin
            r.id = tid[i];
            r.key = tkey[i];
            r.last = (i + 1 == n);
            enqueue(r);
          end
        end else begin
          for (int i = 0; i < n; i++) begin
            sum += tkey[i];
            keys[tid[i]] = tkey[i];
            sift_up(slot_of[tid[i]]);
          end
          r.total = sum;
          enqueue(r);
        end
      end
    endcase
  endfunction

  initial begin
    errors = 0;
    results_seen = 0;
    pending = 0;
    fill = 0;
  end

  always @(posedge clk) begin
    heap_result_t e;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready)
        predict(in_ch.action, in_ch.entry_id, in_ch.key_value, in_ch.take_count);
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          $error("unexpected result transfer");
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (out_ch.out_id !== e.id) begin
            $error("out_id: expected %0d, got %0d", e.id, out_ch.out_id); errors++;
          end
          if (out_ch.out_key !== e.key) begin
            $error("out_key: expected %0d, got %0d", e.key, out_ch.out_key); errors++;
          end
          if (out_ch.total !== e.total) begin
            $error("total: expected %0d, got %0d", e.total, out_ch.total); errors++;
          end
          if (out_ch.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, out_ch.status); errors++;
          end
          if (out_ch.last !== e.last) begin
            $error("last: expected %0d, got %0d", e.last, out_ch.last); errors++;
          end
        end
      end
      pending = expected_q.size();
    end
  end
endmodule

// ===== sim/indexed_max_heap_top_k_tb.sv =====
// Testbench top: clock, reset, request stimulus, result back-pressure and verdict.
module indexed_max_heap_top_k_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ihtk_pkg::*;

  localparam int CAP = 64;

  logic clk;
  logic rst;
  int   errors, pending, results_seen;
  int   send_idle_pct, recv_idle_pct, hold_cycles;
  int   act_count [4];
  bit   inserted [NUM_IDS];
  int   num_inserted;
  int   heap_count;

  ihtk_in_if  in_ch();
  ihtk_out_if out_ch();

  indexed_max_heap_top_k u_top (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  ihtk_scoreboard u_scoreboard (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .errors(errors), .pending(pending), .results_seen(results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("Some tests failed");
    $finish;
  end

  // result side: random stalls, or a long hold-off when requested
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send(logic [ACT_W-1:0] act, logic [ID_W-1:0] id,
                      logic [KEY_W-1:0] key, logic [TAKE_W-1:0] k);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.action     <= act;
    in_ch.entry_id   <= id;
    in_ch.key_value  <= key;
    in_ch.take_count <= k;
    in_ch.valid      <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    act_count[act]++;
    // only an insert into a heap with room writes the entry
    if (act == ACT_INSERT && heap_count < CAP) begin
      heap_count++;
      if (!inserted[id]) begin
        inserted[id] = 1'b1;
        num_inserted++;
      end
    end
  endtask

  function automatic logic [ID_W-1:0] pick_inserted();
    logic [ID_W-1:0] id;
    do id = ID_W'($urandom_range(NUM_IDS - 1)); while (!inserted[id]);
    return id;
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    case ($urandom_range(3))
      0: return KEY_W'($urandom_range(3));
      1: return KEY_W'($urandom_range(40));
      default: return KEY_W'($urandom() & 32'h7fff_ffff);
    endcase
  endfunction

  task automatic random_item();
    int sel;
    logic [TAKE_W-1:0] k;
    sel = $urandom_range(99);
    k = ($urandom_range(9) == 0) ? TAKE_W'($urandom_range(127)) : TAKE_W'($urandom_range(6));
    if (sel < 30 || num_inserted == 0)
      send(ACT_INSERT, ID_W'($urandom_range(NUM_IDS - 1)), rand_key(),
           TAKE_W'($urandom_range(127)));
    else if (sel < 65)
      send(ACT_RAISE, pick_inserted(), rand_key(), TAKE_W'($urandom_range(127)));
    else if (sel < 82)
      send(ACT_TAKE, ID_W'($urandom_range(NUM_IDS - 1)), KEY_W'($urandom()), k);
    else
      send(ACT_REPORT, ID_W'($urandom_range(NUM_IDS - 1)), KEY_W'($urandom()), k);
  endtask

  initial begin
    in_ch.valid      <= 1'b0;
    in_ch.action     <= ACT_INSERT;
    in_ch.entry_id   <= '0;
    in_ch.key_value  <= '0;
    in_ch.take_count <= '0;
    send_idle_pct = 13;
    recv_idle_pct = 49;
    hold_cycles = 0;
    num_inserted = 0;
    heap_count = 0;
    rst <= 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send(ACT_TAKE, 0, 0, 5);
    send(ACT_REPORT, 0, 0, 64);
    send(ACT_INSERT, 63, 31'h7fff_ffff, 0);
    send(ACT_INSERT, 0, 0, 0);
    send(ACT_INSERT, 1, 0, 0);
    send(ACT_INSERT, 2, 0, 0);
    send(ACT_INSERT, 3, 7, 0);
    send(ACT_INSERT, 4, 7, 0);
    send(ACT_INSERT, 63, 12, 0);
    send(ACT_RAISE, 1, 9, 0);
    send(ACT_RAISE, 0, 31'h7fff_ffff, 0);
    send(ACT_TAKE, 0, 0, 0);
    send(ACT_REPORT, 0, 0, 0);
    send(ACT_REPORT, 0, 0, 3);
    send(ACT_TAKE, 0, 0, 2);
    send(ACT_REPORT, 0, 0, 127);
    send(ACT_TAKE, 0, 0, 127);
    send(ACT_RAISE, 2, 5, 0);
    send(ACT_TAKE, 0, 0, 64);

    for (int i = 0; i < 240; i++) begin
      if (i == 80) begin
        send_idle_pct = 49;
        recv_idle_pct = 13;
      end
      if (i == 160) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles = 400;
      end
      random_item();
    end
    // fill to capacity, then overflow
    for (int i = 0; i < 70; i++)
      send(ACT_INSERT, ID_W'($urandom_range(NUM_IDS - 1)), rand_key(), 0);
    send(ACT_TAKE, 0, 0, 64);
    send(ACT_REPORT, 0, 0, 64);
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Requests: %0d insert, %0d raise, %0d take, %0d report; %0d results checked",
             act_count[0], act_count[1], act_count[2], act_count[3], results_seen);
    if (errors == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
